FILE: design/grtg_pkg.sv
// Shared types, constants and state encodings for the gradient ramp texel generator.
// Used by grtg_blend and gradient_ramp_texel_generator_core; depends on nothing.
`default_nettype none

package grtg_pkg;

    localparam int MAX_STOPS      = 16;
    localparam int MAX_RAMP_WIDTH = 1024;

    localparam int STOP_IDX_W = $clog2(MAX_STOPS);
    localparam int CNT_W      = $clog2(MAX_STOPS + 1);
    localparam int SEG_W      = 5;
    localparam int PLACE_W    = 17;
    localparam int FRAC_W     = 16;
    localparam int CHAN_W     = 8;
    localparam int NUM_CHAN   = 4;
    localparam int CH_IDX_W   = $clog2(NUM_CHAN);
    localparam int COLOR_W    = NUM_CHAN * CHAN_W;
    localparam int RW_W       = 11;
    localparam int PROD_W     = PLACE_W + RW_W;
    localparam int NUM_W      = PROD_W + CHAN_W;
    localparam int STEP_W     = $clog2(CHAN_W);
    localparam int CFG_IDX_W  = 1;

    typedef enum logic [1:0] {
        ACT_CLEAR  = 2'd0,
        ACT_APPEND = 2'd1,
        ACT_EMIT   = 2'd2
    } action_e;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_RAMP_WIDTH      = 1'b0,
        CFG_ATLAS_ROW_WIDTH = 1'b1
    } cfg_reg_e;

    typedef enum logic [2:0] {
        S_IDLE,
        S_FIRST,
        S_SEARCH,
        S_PREP,
        S_BLEND_GO,
        S_BLEND_WAIT
    } core_state_e;

    typedef enum logic {
        B_IDLE,
        B_DIV
    } blend_state_e;

    typedef struct packed {
        logic [1:0]         action;
        logic [PLACE_W-1:0] stop_place;
        logic [CHAN_W-1:0]  stop_red;
        logic [CHAN_W-1:0]  stop_green;
        logic [CHAN_W-1:0]  stop_blue;
        logic [CHAN_W-1:0]  stop_alpha;
    } cmd_t;

    typedef struct packed {
        logic [CHAN_W-1:0] texel_red;
        logic [CHAN_W-1:0] texel_green;
        logic [CHAN_W-1:0] texel_blue;
        logic [CHAN_W-1:0] texel_alpha;
        logic [RW_W-1:0]   texel_index;
        logic              last_texel;
        logic              status;
    } texel_t;

    // One channel blend job: c0 + (c1 - c0) * n / d, rounded down (toward the lower value).
    typedef struct packed {
        logic [PROD_W-1:0] n;
        logic [PROD_W-1:0] d;
        logic [CHAN_W-1:0] c0;
        logic [CHAN_W-1:0] c1;
    } blend_req_t;

endpackage

`default_nettype wire

FILE: design/grtg_blend.sv
// Iterative channel blend unit: one multiply, then restoring division one bit a cycle.
// Depends on grtg_pkg.
`default_nettype none

module grtg_blend (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       go,
    input  wire grtg_pkg::blend_req_t       req,
    output logic                            done,
    output logic [grtg_pkg::CHAN_W-1:0]     value
);

    grtg_pkg::blend_state_e state_reg, state_next;

    logic [grtg_pkg::NUM_W-1:0]  rem_reg, rem_next;
    logic [grtg_pkg::NUM_W-1:0]  dsh_reg, dsh_next;
    logic [grtg_pkg::CHAN_W-1:0] q_reg, q_next;
    logic [grtg_pkg::CHAN_W-1:0] c0_reg, c0_next;
    logic [grtg_pkg::CHAN_W-1:0] value_reg, value_next;
    logic                        down_reg, down_next;
    logic                        dzero_reg, dzero_next;
    logic [grtg_pkg::STEP_W-1:0] step_reg, step_next;
    logic                        done_reg, done_next;

    logic [grtg_pkg::CHAN_W-1:0] diff;
    logic [grtg_pkg::NUM_W-1:0]  product;
    logic                        ge;
    logic [grtg_pkg::NUM_W-1:0]  sub;
    logic [grtg_pkg::NUM_W-1:0]  rem_after;
    logic [grtg_pkg::CHAN_W-1:0] qn;

    assign diff = (req.c1 >= req.c0) ? (req.c1 - req.c0) : (req.c0 - req.c1);
    assign product = {{grtg_pkg::CHAN_W{1'b0}}, req.n} * {{grtg_pkg::PROD_W{1'b0}}, diff};

    assign ge        = rem_reg >= dsh_reg;
    assign sub       = rem_reg - dsh_reg;
    assign rem_after = ge ? sub : rem_reg;
    assign qn        = {q_reg[grtg_pkg::CHAN_W-2:0], ge};

    always_comb
    begin
        state_next = state_reg;
        rem_next   = rem_reg;
        dsh_next   = dsh_reg;
        q_next     = q_reg;
        c0_next    = c0_reg;
        value_next = value_reg;
        down_next  = down_reg;
        dzero_next = dzero_reg;
        step_next  = step_reg;
        done_next  = 1'b0;
        unique case (state_reg)
            grtg_pkg::B_IDLE:
            begin
                if (go)
                begin
                    rem_next   = product;
                    // quotient fits CHAN_W bits since n <= d
                    dsh_next   = {1'b0, req.d, {(grtg_pkg::CHAN_W-1){1'b0}}};
                    q_next     = '0;
                    c0_next    = req.c0;
                    down_next  = req.c1 < req.c0;
                    dzero_next = req.d == '0;
                    step_next  = '0;
                    state_next = grtg_pkg::B_DIV;
                end
            end
            grtg_pkg::B_DIV:
            begin
                rem_next  = rem_after;
                q_next    = qn;
                dsh_next  = dsh_reg >> 1;
                step_next = step_reg + grtg_pkg::STEP_W'(1);
                if (step_reg == grtg_pkg::STEP_W'(grtg_pkg::CHAN_W - 1))
                begin
                    state_next = grtg_pkg::B_IDLE;
                    done_next  = 1'b1;
                    if (dzero_reg)
                        value_next = c0_reg;
                    else if (down_reg)
                        // falling channel: subtract the rounded-up quotient
                        value_next = c0_reg - qn
                                     - grtg_pkg::CHAN_W'(rem_after != '0);
                    else
                        value_next = c0_reg + qn;
                end
            end
            default:
            begin
                state_next = grtg_pkg::B_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= grtg_pkg::B_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg   <= rem_next;
        dsh_reg   <= dsh_next;
        q_reg     <= q_next;
        c0_reg    <= c0_next;
        value_reg <= value_next;
        down_reg  <= down_next;
        dzero_reg <= dzero_next;
        step_reg  <= step_next;
    end

    assign done  = done_reg;
    assign value = value_reg;

endmodule

`default_nettype wire

FILE: design/gradient_ramp_texel_generator_core.sv
// Gradient ramp texel generator: stop store, segment search sequencer, result register.
// Clear and append complete at their transfer; a refused emit strobes in the cycle after its transfer.
// Emit: search the stops (k = stop index reached, up to 15), then blend if the texel is interpolated.
// Blending runs the 4 channels in turn on the single blend unit: a start, 8 divide steps, a handoff.
// One item at a time: busy is high until the result strobes; the receiver cannot stall.
// Reset: stop list empty, ramp at texel 0, ramp_width 256, atlas_row_width 1024.
// Depends on grtg_pkg and grtg_blend.
`default_nettype none

module gradient_ramp_texel_generator_core (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              start,
    output logic                                   busy,
    input  wire grtg_pkg::cmd_t                    cmd,
    output logic                                   done,
    output grtg_pkg::texel_t                       texel,
    input  wire logic                              cfg_we,
    input  wire logic [grtg_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [grtg_pkg::RW_W-1:0]         cfg_wdata
);

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [grtg_pkg::RW_W-1:0] ramp_width_reg;
    logic [grtg_pkg::RW_W-1:0] atlas_width_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ramp_width_reg  <= grtg_pkg::RW_W'(256);
            atlas_width_reg <= grtg_pkg::RW_W'(grtg_pkg::MAX_RAMP_WIDTH);
        end
        else if (cfg_we)
        begin
            if (cfg_index == grtg_pkg::CFG_RAMP_WIDTH)
                ramp_width_reg <= cfg_wdata;
            else
                atlas_width_reg <= cfg_wdata;
        end
    end

    // ------------------------------------------------------------------
    // Ramp shape: width clamped to the atlas row, slack where it fits
    // ------------------------------------------------------------------
    logic [grtg_pkg::RW_W-1:0] r_eff;
    logic [grtg_pkg::RW_W-1:0] a_eff;
    logic [grtg_pkg::RW_W-1:0] shape_w;
    logic                      shape_s;
    logic                      shape_e;
    logic [grtg_pkg::RW_W-1:0] shape_total;

    always_comb
    begin
        r_eff = (ramp_width_reg == '0) ? grtg_pkg::RW_W'(1) : ramp_width_reg;
        if (atlas_width_reg == '0)
            a_eff = grtg_pkg::RW_W'(1);
        else if (atlas_width_reg > grtg_pkg::RW_W'(grtg_pkg::MAX_RAMP_WIDTH))
            a_eff = grtg_pkg::RW_W'(grtg_pkg::MAX_RAMP_WIDTH);
        else
            a_eff = atlas_width_reg;

        priority if (r_eff >= a_eff)
        begin
            shape_w = a_eff;
            shape_s = 1'b0;
            shape_e = 1'b0;
        end
        else if (r_eff == a_eff - grtg_pkg::RW_W'(1))
        begin
            // room for the end slack only
            shape_w = r_eff;
            shape_s = 1'b0;
            shape_e = 1'b1;
        end
        else
        begin
            shape_w = r_eff;
            shape_s = 1'b1;
            shape_e = 1'b1;
        end
        shape_total = shape_w + grtg_pkg::RW_W'(shape_s) + grtg_pkg::RW_W'(shape_e);
    end

    // ------------------------------------------------------------------
    // Stop store: place and color arrays, registered read port
    // ------------------------------------------------------------------
    logic [grtg_pkg::PLACE_W-1:0] place_mem [grtg_pkg::MAX_STOPS];
    logic [grtg_pkg::COLOR_W-1:0] color_mem [grtg_pkg::MAX_STOPS];
    logic [grtg_pkg::PLACE_W-1:0] place_rd_reg;
    logic [grtg_pkg::COLOR_W-1:0] color_rd_reg;
    logic [grtg_pkg::STOP_IDX_W-1:0] rd_addr;
    logic                            mem_we;

    // ------------------------------------------------------------------
    // Sequencer state
    // ------------------------------------------------------------------
    grtg_pkg::core_state_e state_reg, state_next;

    logic [grtg_pkg::CNT_W-1:0]      count_reg, count_next;
    logic [grtg_pkg::RW_W-1:0]       next_texel_reg, next_texel_next;
    logic [grtg_pkg::SEG_W-1:0]      seg_reg, seg_next;

    logic [grtg_pkg::RW_W-1:0]       i_reg, i_next;
    logic [grtg_pkg::RW_W-1:0]       w_reg, w_next;
    logic [grtg_pkg::RW_W-1:0]       total_reg, total_next;
    logic [grtg_pkg::PROD_W-1:0]     tn_reg, tn_next;
    logic                            tn_neg_reg, tn_neg_next;
    logic [grtg_pkg::STOP_IDX_W-1:0] k_reg, k_next;
    logic [grtg_pkg::PROD_W-1:0]     prev_prod_reg, prev_prod_next;
    logic [grtg_pkg::PROD_W-1:0]     cur_prod_reg, cur_prod_next;
    logic [grtg_pkg::COLOR_W-1:0]    prev_color_reg, prev_color_next;
    logic [grtg_pkg::COLOR_W-1:0]    cur_color_reg, cur_color_next;
    logic [grtg_pkg::PROD_W-1:0]     n_reg, n_next;
    logic [grtg_pkg::PROD_W-1:0]     d_reg, d_next;
    logic [grtg_pkg::COLOR_W-1:0]    acc_reg, acc_next;
    logic [grtg_pkg::CH_IDX_W-1:0]   ch_reg, ch_next;

    logic                            done_reg, done_next;
    grtg_pkg::texel_t                texel_reg, texel_next;

    // place[k] * W for the stop just read
    logic [grtg_pkg::PROD_W-1:0] prod;
    assign prod = {{grtg_pkg::RW_W{1'b0}}, place_rd_reg}
                * {{grtg_pkg::PLACE_W{1'b0}}, w_reg};

    // shared blend unit
    logic                        blend_go;
    grtg_pkg::blend_req_t        blend_req;
    logic                        blend_done;
    logic [grtg_pkg::CHAN_W-1:0] blend_value;

    grtg_blend u_blend (
        .clk   (clk),
        .rst_n (rst_n),
        .go    (blend_go),
        .req   (blend_req),
        .done  (blend_done),
        .value (blend_value)
    );

    logic accept;
    assign accept = start && (state_reg == grtg_pkg::S_IDLE);

    always_comb
    begin
        logic                         fin;
        logic [grtg_pkg::COLOR_W-1:0] fin_color;
        logic [grtg_pkg::SEG_W-1:0]   fin_seg;
        logic [grtg_pkg::RW_W-1:0]    i_off;
        logic [grtg_pkg::PROD_W-1:0]  n_raw;
        logic [grtg_pkg::PROD_W-1:0]  d_raw;

        fin       = 1'b0;
        fin_color = '0;
        fin_seg   = '0;
        i_off     = next_texel_reg - grtg_pkg::RW_W'(shape_s);
        n_raw     = (tn_reg > prev_prod_reg) ? (tn_reg - prev_prod_reg) : '0;
        d_raw     = (cur_prod_reg > prev_prod_reg) ? (cur_prod_reg - prev_prod_reg) : '0;

        state_next      = state_reg;
        count_next      = count_reg;
        next_texel_next = next_texel_reg;
        seg_next        = seg_reg;
        i_next          = i_reg;
        w_next          = w_reg;
        total_next      = total_reg;
        tn_next         = tn_reg;
        tn_neg_next     = tn_neg_reg;
        k_next          = k_reg;
        prev_prod_next  = prev_prod_reg;
        cur_prod_next   = cur_prod_reg;
        prev_color_next = prev_color_reg;
        cur_color_next  = cur_color_reg;
        n_next          = n_reg;
        d_next          = d_reg;
        acc_next        = acc_reg;
        ch_next         = ch_reg;
        done_next       = 1'b0;
        texel_next      = texel_reg;
        rd_addr         = '0;
        mem_we          = 1'b0;
        blend_go        = 1'b0;
        blend_req.n     = n_reg;
        blend_req.d     = d_reg;
        blend_req.c0    = prev_color_reg[ch_reg*grtg_pkg::CHAN_W +: grtg_pkg::CHAN_W];
        blend_req.c1    = cur_color_reg[ch_reg*grtg_pkg::CHAN_W +: grtg_pkg::CHAN_W];

        unique case (state_reg)
            grtg_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    unique case (cmd.action)
                        grtg_pkg::ACT_CLEAR:
                        begin
                            count_next      = '0;
                            next_texel_next = '0;
                            seg_next        = '0;
                        end
                        grtg_pkg::ACT_APPEND:
                        begin
                            // full list: stop dropped
                            if (count_reg < grtg_pkg::CNT_W'(grtg_pkg::MAX_STOPS))
                            begin
                                mem_we     = 1'b1;
                                count_next = count_reg + grtg_pkg::CNT_W'(1);
                            end
                        end
                        grtg_pkg::ACT_EMIT:
                        begin
                            if (count_reg == '0 || next_texel_reg >= shape_total)
                            begin
                                done_next         = 1'b1;
                                texel_next        = '0;
                                texel_next.status = 1'b1;
                            end
                            else
                            begin
                                i_next      = next_texel_reg;
                                w_next      = shape_w;
                                total_next  = shape_total;
                                // t scaled by 65536 * W; negative only for the start slack
                                tn_next     = grtg_pkg::PROD_W'({i_off,
                                                                {grtg_pkg::FRAC_W{1'b0}}});
                                tn_neg_next = shape_s && (next_texel_reg == '0);
                                rd_addr     = '0;
                                state_next  = grtg_pkg::S_FIRST;
                            end
                        end
                        default:
                        begin
                            // unused action code: no effect
                        end
                    endcase
                end
            end
            grtg_pkg::S_FIRST:
            begin
                if (tn_neg_reg || tn_reg <= prod)
                begin
                    fin       = 1'b1;
                    fin_color = color_rd_reg;
                end
                else
                begin
                    prev_prod_next  = prod;
                    prev_color_next = color_rd_reg;
                    if (count_reg == grtg_pkg::CNT_W'(1))
                    begin
                        fin       = 1'b1;
                        fin_color = color_rd_reg;
                    end
                    else
                    begin
                        k_next     = grtg_pkg::STOP_IDX_W'(1);
                        rd_addr    = grtg_pkg::STOP_IDX_W'(1);
                        state_next = grtg_pkg::S_SEARCH;
                    end
                end
            end
            grtg_pkg::S_SEARCH:
            begin
                if (tn_reg < prod)
                begin
                    cur_prod_next  = prod;
                    cur_color_next = color_rd_reg;
                    state_next     = grtg_pkg::S_PREP;
                end
                else if (grtg_pkg::CNT_W'(k_reg) + grtg_pkg::CNT_W'(1) == count_reg)
                begin
                    // past the last stop
                    fin       = 1'b1;
                    fin_color = color_rd_reg;
                end
                else
                begin
                    prev_prod_next  = prod;
                    prev_color_next = color_rd_reg;
                    k_next          = k_reg + grtg_pkg::STOP_IDX_W'(1);
                    rd_addr         = k_reg + grtg_pkg::STOP_IDX_W'(1);
                end
            end
            grtg_pkg::S_PREP:
            begin
                // clamp 0 <= n <= d for out-of-order places
                n_next     = (n_raw > d_raw) ? d_raw : n_raw;
                d_next     = d_raw;
                ch_next    = '0;
                state_next = grtg_pkg::S_BLEND_GO;
            end
            grtg_pkg::S_BLEND_GO:
            begin
                blend_go   = 1'b1;
                state_next = grtg_pkg::S_BLEND_WAIT;
            end
            grtg_pkg::S_BLEND_WAIT:
            begin
                if (blend_done)
                begin
                    acc_next[ch_reg*grtg_pkg::CHAN_W +: grtg_pkg::CHAN_W] = blend_value;
                    if (ch_reg == grtg_pkg::CH_IDX_W'(grtg_pkg::NUM_CHAN - 1))
                    begin
                        fin       = 1'b1;
                        fin_color = {blend_value,
                                     acc_reg[grtg_pkg::COLOR_W-grtg_pkg::CHAN_W-1:0]};
                        fin_seg   = grtg_pkg::SEG_W'(k_reg);
                    end
                    else
                    begin
                        ch_next    = ch_reg + grtg_pkg::CH_IDX_W'(1);
                        state_next = grtg_pkg::S_BLEND_GO;
                    end
                end
            end
            default:
            begin
                state_next = grtg_pkg::S_IDLE;
            end
        endcase

        if (fin)
        begin
            done_next              = 1'b1;
            texel_next.texel_red   = fin_color[0*grtg_pkg::CHAN_W +: grtg_pkg::CHAN_W];
            texel_next.texel_green = fin_color[1*grtg_pkg::CHAN_W +: grtg_pkg::CHAN_W];
            texel_next.texel_blue  = fin_color[2*grtg_pkg::CHAN_W +: grtg_pkg::CHAN_W];
            texel_next.texel_alpha = fin_color[3*grtg_pkg::CHAN_W +: grtg_pkg::CHAN_W];
            texel_next.texel_index = i_reg;
            texel_next.last_texel  = (i_reg + grtg_pkg::RW_W'(1)) == total_reg;
            texel_next.status      = 1'b0;
            next_texel_next        = i_reg + grtg_pkg::RW_W'(1);
            seg_next               = fin_seg;
            state_next             = grtg_pkg::S_IDLE;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= grtg_pkg::S_IDLE;
            count_reg      <= '0;
            next_texel_reg <= '0;
            seg_reg        <= '0;
            done_reg       <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            count_reg      <= count_next;
            next_texel_reg <= next_texel_next;
            seg_reg        <= seg_next;
            done_reg       <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        i_reg          <= i_next;
        w_reg          <= w_next;
        total_reg      <= total_next;
        tn_reg         <= tn_next;
        tn_neg_reg     <= tn_neg_next;
        k_reg          <= k_next;
        prev_prod_reg  <= prev_prod_next;
        cur_prod_reg   <= cur_prod_next;
        prev_color_reg <= prev_color_next;
        cur_color_reg  <= cur_color_next;
        n_reg          <= n_next;
        d_reg          <= d_next;
        acc_reg        <= acc_next;
        ch_reg         <= ch_next;
        texel_reg      <= texel_next;
    end

    // stop store write at the fill count, read one stop per cycle
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            place_mem[count_reg[grtg_pkg::STOP_IDX_W-1:0]] <= cmd.stop_place;
            color_mem[count_reg[grtg_pkg::STOP_IDX_W-1:0]] <= {cmd.stop_alpha, cmd.stop_blue,
                                                              cmd.stop_green, cmd.stop_red};
        end
        place_rd_reg <= place_mem[rd_addr];
        color_rd_reg <= color_mem[rd_addr];
    end

    assign busy  = state_reg != grtg_pkg::S_IDLE;
    assign done  = done_reg;
    assign texel = texel_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_done_has_cause: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> ($past(busy) || $past(start)))
        else $error("result strobe without a transfer in flight");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= grtg_pkg::CNT_W'(grtg_pkg::MAX_STOPS))
        else $error("stop count beyond capacity");

    a_busy_needs_stops: assert property (@(posedge clk) disable iff (!rst_n)
        busy |-> (count_reg != '0))
        else $error("emit in progress with an empty stop list");

    a_refused_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && texel.status) |-> (texel.texel_index == '0 && !texel.last_texel
            && texel.texel_red == '0 && texel.texel_green == '0
            && texel.texel_blue == '0 && texel.texel_alpha == '0))
        else $error("refused emit carries nonzero fields");

    a_ok_advances: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !texel.status) |->
            (next_texel_reg == texel.texel_index + grtg_pkg::RW_W'(1)
             && (grtg_pkg::CNT_W + grtg_pkg::SEG_W)'(seg_reg)
                < (grtg_pkg::CNT_W + grtg_pkg::SEG_W)'(count_reg)))
        else $error("texel pointer or segment inconsistent with emitted texel");

endmodule

`default_nettype wire

FILE: tb/gradient_ramp_texel_generator_core_tb.sv
// Self-checking testbench for gradient_ramp_texel_generator_core: directed table, then random ramps.
// Each transfer runs through a local texel predictor; results are checked against its queue.
// Depends on grtg_pkg and the core RTL.
`default_nettype none

module gradient_ramp_texel_generator_core_tb;

    import grtg_pkg::*;

    // Action code the block ignores (no result).
    localparam logic [1:0] ACT_IGNORED = 2'd3;

    localparam int ITEM_GOAL    = 1900;
    localparam int QUIET_CYCLES = 64;   // longer than the slowest emit

    localparam texel_t TEXEL_REFUSED = texel_t'{8'h00, 8'h00, 8'h00, 8'h00, 11'd0, 1'b0, 1'b1};

    typedef struct {
        bit              is_cfg;
        cfg_reg_e        reg_sel;
        logic [RW_W-1:0] reg_val;
        cmd_t            c;
        bit              typed;     // want holds the expected texel
        texel_t          want;
    } stim_row_t;

    logic            clk = 1'b0;
    logic            rst_n;
    logic            start;
    logic            busy;
    cmd_t            cmd;
    logic            done;
    texel_t          texel;
    logic            cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [RW_W-1:0] cfg_wdata;

    // Predictor copy of the block state and registers.
    logic [PLACE_W-1:0] place_mem [MAX_STOPS];
    logic [COLOR_W-1:0] color_mem [MAX_STOPS];   // red in 7:0 ... alpha in 31:24
    int                 n_stops   = 0;
    int                 texel_ptr = 0;
    logic [RW_W-1:0]    rw_reg    = 11'd256;
    logic [RW_W-1:0]    aw_reg    = 11'd1024;

    texel_t    texel_due [$];
    stim_row_t dir_rows [$];
    int        fail_cnt   = 0;
    int        items_sent = 0;
    int        idle_pct   = 32;

    gradient_ramp_texel_generator_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .cmd       (cmd),
        .done      (done),
        .texel     (texel),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Append one expected texel to the pending queue.
    function automatic void due_add(input texel_t t);
        texel_due = {texel_due, t};
    endfunction

    // Append one row to the directed table.
    function automatic void add_row(input stim_row_t r);
        dir_rows = {dir_rows, r};
    endfunction

    // Width and slack from the current registers (zero reads as one, atlas clamped).
    function automatic void ramp_shape(output int w, output int s, output int e);
        int r;
        int a;
        r = (rw_reg == 0) ? 1 : int'(rw_reg);
        a = (aw_reg == 0) ? 1 : int'(aw_reg);
        if (a > MAX_RAMP_WIDTH)
            a = MAX_RAMP_WIDTH;
        if (r >= a)
        begin
            w = a; s = 0; e = 0;
        end
        else if (r == a - 1)
        begin
            w = r; s = 0; e = 1;
        end
        else
        begin
            w = r; s = 1; e = 1;
        end
    endfunction

    // c0 + (c1 - c0) * n / d, truncated toward the lower value of the exact result.
    function automatic logic [CHAN_W-1:0] mix_chan(input logic [CHAN_W-1:0] c0,
                                                   input logic [CHAN_W-1:0] c1,
                                                   input longint n, input longint d);
        longint lo;
        longint hi;
        lo = longint'(c0);
        hi = longint'(c1);
        if (d == 0)
            return c0;
        if (hi >= lo)
            return CHAN_W'(lo + (n * (hi - lo)) / d);
        return CHAN_W'(lo - (n * (lo - hi) + d - 1) / d);
    endfunction

    // Texel predictor: updates local state, returns 1 when the command yields a texel.
    function automatic bit ramp_predict(input cmd_t c, output texel_t t);
        int w, s, e, total, k, ch;
        longint tn, nn, dd;
        logic [COLOR_W-1:0] ca, cb, col;
        t = '0;
        case (c.action)
            ACT_CLEAR:
            begin
                n_stops   = 0;
                texel_ptr = 0;
                return 1'b0;
            end
            ACT_APPEND:
            begin
                if (n_stops < MAX_STOPS)
                begin
                    place_mem[n_stops] = c.stop_place;
                    color_mem[n_stops] = {c.stop_alpha, c.stop_blue, c.stop_green, c.stop_red};
                    n_stops++;
                end
                return 1'b0;
            end
            ACT_EMIT: ;
            default: return 1'b0;
        endcase

        ramp_shape(w, s, e);
        total = w + s + e;
        if (n_stops == 0 || texel_ptr >= total)
        begin
            t.status = 1'b1;
            return 1'b1;
        end

        tn = (longint'(texel_ptr) - s) * 65536;
        if (tn <= longint'(place_mem[0]) * w)
            col = color_mem[0];
        else
        begin
            // first later stop strictly beyond t; equal places never win
            for (k = 1; k < n_stops; k++)
                if (tn < longint'(place_mem[k]) * w)
                    break;
            if (k >= n_stops)
                col = color_mem[n_stops-1];
            else
            begin
                ca = color_mem[k-1];
                cb = color_mem[k];
                nn = tn - longint'(place_mem[k-1]) * w;
                dd = (longint'(place_mem[k]) - longint'(place_mem[k-1])) * w;
                if (nn < 0) nn = 0;
                if (dd < 0) dd = 0;
                if (nn > dd) nn = dd;
                for (ch = 0; ch < NUM_CHAN; ch++)
                    col[ch*CHAN_W +: CHAN_W] = mix_chan(ca[ch*CHAN_W +: CHAN_W],
                                                        cb[ch*CHAN_W +: CHAN_W], nn, dd);
            end
        end

        t.texel_red   = col[7:0];
        t.texel_green = col[15:8];
        t.texel_blue  = col[23:16];
        t.texel_alpha = col[31:24];
        t.texel_index = RW_W'(texel_ptr);
        t.last_texel  = (texel_ptr + 1 == total);
        texel_ptr     = texel_ptr + 1;
        return 1'b1;
    endfunction

    function automatic cmd_t rand_cmd(input logic [1:0] act);
        cmd_t c;
        c.action     = act;
        c.stop_place = PLACE_W'($urandom_range(0, 131071));
        c.stop_red   = CHAN_W'($urandom());
        c.stop_green = CHAN_W'($urandom());
        c.stop_blue  = CHAN_W'($urandom());
        c.stop_alpha = CHAN_W'($urandom());
        return c;
    endfunction

    // rgba is written 32'hRRGGBBAA in the table.
    function automatic stim_row_t cmd_row(input logic [1:0] act, input logic [PLACE_W-1:0] place,
                                          input logic [31:0] rgba);
        stim_row_t r;
        r.is_cfg       = 1'b0;
        r.reg_val      = '0;
        r.c.action     = act;
        r.c.stop_place = place;
        r.c.stop_red   = rgba[31:24];
        r.c.stop_green = rgba[23:16];
        r.c.stop_blue  = rgba[15:8];
        r.c.stop_alpha = rgba[7:0];
        r.typed        = 1'b0;
        r.want         = '0;
        return r;
    endfunction

    function automatic stim_row_t emit_row(input texel_t want);
        stim_row_t r;
        r       = cmd_row(ACT_EMIT, '0, 32'h0);
        r.typed = 1'b1;
        r.want  = want;
        return r;
    endfunction

    function automatic stim_row_t cfg_row(input cfg_reg_e sel, input logic [RW_W-1:0] v);
        stim_row_t r;
        r         = cmd_row(ACT_IGNORED, '0, 32'h0);
        r.is_cfg  = 1'b1;
        r.reg_sel = sel;
        r.reg_val = v;
        return r;
    endfunction

    // wait_quiet, write_reg and send_cmd enter and leave just after a falling edge.
    task automatic wait_quiet();
        start <= 1'b0;
        @(negedge clk);
        while (texel_due.size() != 0 || busy)
            @(negedge clk);
    endtask

    // Register writes only with the block idle; extra hold-off covers result-less work.
    task automatic write_reg(input cfg_reg_e sel, input logic [RW_W-1:0] v);
        wait_quiet();
        repeat (QUIET_CYCLES) @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= sel;
        cfg_wdata <= v;
        @(negedge clk);
        cfg_we    <= 1'b0;
        case (sel)
            CFG_RAMP_WIDTH:      rw_reg = v;
            CFG_ATLAS_ROW_WIDTH: aw_reg = v;
            default: ;
        endcase
    endtask

    // One command transfer; start stays high on return so back-to-back items need no gap.
    task automatic send_cmd(input cmd_t c, input bit typed, input texel_t want);
        texel_t got;
        while ($urandom_range(0, 99) < idle_pct)
        begin
            start <= 1'b0;
            @(negedge clk);
        end
        start <= 1'b1;
        cmd   <= c;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        if (ramp_predict(c, got))
            due_add(typed ? want : got);
        if (c.action != ACT_IGNORED)
            items_sent++;
        @(negedge clk);
    endtask

    task automatic check_field(input string tag, input int want_v, input int got_v);
        if (want_v != got_v)
        begin
            fail_cnt++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, tag, want_v, got_v);
        end
    endtask

    // Result checker: every strobe must match the oldest pending texel.
    always @(posedge clk)
    begin : result_check
        texel_t want;
        if (rst_n && done)
        begin
            if (texel_due.size() == 0)
            begin
                fail_cnt++;
                $display("%0t: unexpected texel, expected none, actual index %0d status %0d",
                         $time, texel.texel_index, texel.status);
            end
            else
            begin
                want = texel_due.pop_front();
                check_field("texel_red",   want.texel_red,   texel.texel_red);
                check_field("texel_green", want.texel_green, texel.texel_green);
                check_field("texel_blue",  want.texel_blue,  texel.texel_blue);
                check_field("texel_alpha", want.texel_alpha, texel.texel_alpha);
                check_field("texel_index", want.texel_index, texel.texel_index);
                check_field("last_texel",  want.last_texel,  texel.last_texel);
                check_field("status",      want.status,      texel.status);
            end
        end
    end

    initial
    begin
        #2000000;
        $display("Regression FAIL");
        $finish;
    end

    initial
    begin
        cmd_t            c;
        logic [RW_W-1:0] rw, aw;
        int              sel, nst, n_emit, p, j, roll, w, s, e;
        bit              wide, swap_mid;

        rst_n     = 1'b0;
        start     = 1'b0;
        cmd       = '0;
        cfg_we    = 1'b0;
        cfg_index = '0;
        cfg_wdata = '0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed table. Ramp of width 2 in an atlas of 8: one slack texel each side.
        add_row(emit_row(TEXEL_REFUSED));                       // no stops yet
        add_row(cmd_row(ACT_IGNORED, 17'h1FFFF, 32'hFFFFFFFF));
        add_row(cfg_row(CFG_RAMP_WIDTH, 11'd2));
        add_row(cfg_row(CFG_ATLAS_ROW_WIDTH, 11'd8));
        add_row(cmd_row(ACT_APPEND, 17'd0, 32'h00000000));
        add_row(cmd_row(ACT_APPEND, 17'd65536, 32'hFFFFFFFF));
        add_row(emit_row(texel_t'{8'h00, 8'h00, 8'h00, 8'h00, 11'd0, 1'b0, 1'b0}));
        add_row(emit_row(texel_t'{8'h00, 8'h00, 8'h00, 8'h00, 11'd1, 1'b0, 1'b0}));
        add_row(cmd_row(ACT_EMIT, 17'd0, 32'h0));                // midpoint blend
        add_row(emit_row(texel_t'{8'hFF, 8'hFF, 8'hFF, 8'hFF, 11'd3, 1'b1, 1'b0}));
        add_row(emit_row(TEXEL_REFUSED));                       // ramp finished
        // Equal places, a place above 1.0, then one out of order.
        add_row(cmd_row(ACT_CLEAR, 17'h1FFFF, 32'hA5A5A5A5));
        add_row(cmd_row(ACT_APPEND, 17'h04000, 32'hFF008001));
        add_row(cmd_row(ACT_APPEND, 17'h04000, 32'h00FF7FFE));
        add_row(cmd_row(ACT_APPEND, 17'h1FFFF, 32'h10203040));
        add_row(cmd_row(ACT_APPEND, 17'h00800, 32'hC0C0C0C0));
        add_row(cmd_row(ACT_EMIT, 17'd0, 32'h0));
        add_row(cmd_row(ACT_EMIT, 17'd0, 32'h0));
        add_row(cmd_row(ACT_EMIT, 17'd0, 32'h0));
        // Shrink mid-ramp: zero width reads as one, total 3, texel 3 is past the end.
        add_row(cfg_row(CFG_RAMP_WIDTH, 11'd0));
        add_row(emit_row(TEXEL_REFUSED));
        // Widest setting: atlas clamps to the maximum, ramp resumes at texel 3.
        add_row(cfg_row(CFG_RAMP_WIDTH, 11'h7FF));
        add_row(cfg_row(CFG_ATLAS_ROW_WIDTH, 11'h7FF));
        add_row(cmd_row(ACT_EMIT, 17'd0, 32'h0));
        // Zero atlas reads as one texel: refused.
        add_row(cfg_row(CFG_ATLAS_ROW_WIDTH, 11'd0));
        add_row(emit_row(TEXEL_REFUSED));

        foreach (dir_rows[i])
        begin
            if (dir_rows[i].is_cfg)
                write_reg(dir_rows[i].reg_sel, dir_rows[i].reg_val);
            else
                send_cmd(dir_rows[i].c, dir_rows[i].typed, dir_rows[i].want);
        end

        // Random ramps: pick a shape, load stops, walk the ramp and a bit past its end (large ones only partly).
        while (items_sent < ITEM_GOAL)
        begin
            if (items_sent < ITEM_GOAL / 3)
                idle_pct = 32;
            else if (items_sent < 2 * ITEM_GOAL / 3)
                idle_pct = 62;
            else
                idle_pct = 0;

            sel  = $urandom_range(0, 31);
            wide = 1'b0;
            if (sel < 2)
            begin
                // large ramp, walked only partly
                wide = 1'b1;
                rw   = RW_W'($urandom_range(512, 2047));
                aw   = $urandom_range(0, 1) ? 11'd1024 : RW_W'($urandom_range(600, 2047));
            end
            else if (sel < 4)
            begin
                rw = $urandom_range(0, 1) ? RW_W'($urandom_range(0, 2)) : 11'h7FF;
                aw = RW_W'($urandom_range(0, 3));
            end
            else if (sel == 4)
            begin
                aw = RW_W'($urandom_range(64, 160));
                rw = RW_W'($urandom_range(60, aw));
            end
            else
            begin
                aw   = RW_W'($urandom_range(1, 40));
                roll = $urandom_range(0, 3);
                case (roll)
                    0:       rw = aw;
                    1:       rw = aw - 1'b1;
                    2:       rw = RW_W'($urandom_range(aw, aw + 8));
                    default: rw = RW_W'($urandom_range(0, aw));
                endcase
            end
            if ($urandom_range(0, 1))
            begin
                write_reg(CFG_RAMP_WIDTH, rw);
                write_reg(CFG_ATLAS_ROW_WIDTH, aw);
            end
            else
            begin
                write_reg(CFG_ATLAS_ROW_WIDTH, aw);
                write_reg(CFG_RAMP_WIDTH, rw);
            end

            // Usually restart; sometimes keep the old list so appends pile past capacity.
            if ($urandom_range(0, 9) != 0)
                send_cmd(rand_cmd(ACT_CLEAR), 1'b0, '0);

            roll = $urandom_range(0, 19);
            nst  = (roll == 0) ? 0 : ((roll == 1) ? $urandom_range(15, 19) : $urandom_range(1, 6));
            p    = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 30000);
            for (j = 0; j < nst; j++)
            begin
                c    = rand_cmd(ACT_APPEND);
                roll = $urandom_range(0, 19);
                if (j > 0)
                begin
                    if (roll == 0)
                        ;                              // repeat the place: empty segment
                    else if (roll == 1)
                        p = $urandom_range(0, 131071); // anywhere, order broken
                    else if (roll == 2)
                        p = 65536;
                    else
                    begin
                        p = p + $urandom_range(1, 30000);
                        if (p > 65536)
                            p = 65536;
                    end
                end
                c.stop_place = PLACE_W'(p);
                send_cmd(c, 1'b0, '0);
            end

            ramp_shape(w, s, e);
            n_emit   = wide ? $urandom_range(16, 48) : (w + s + e + $urandom_range(0, 2));
            swap_mid = ($urandom_range(0, 7) == 0);
            for (j = 0; j < n_emit; j++)
            begin
                if (swap_mid && j == n_emit / 2)
                    write_reg(CFG_RAMP_WIDTH, RW_W'($urandom_range(0, 48)));
                roll = $urandom_range(0, 199);
                if (roll < 6)
                    send_cmd(rand_cmd(ACT_IGNORED), 1'b0, '0);
                else if (roll < 8)
                    send_cmd(rand_cmd(ACT_APPEND), 1'b0, '0);
                else if (roll == 8)
                    send_cmd(rand_cmd(ACT_CLEAR), 1'b0, '0);
                else if (roll < 11)
                    wait_quiet();
                send_cmd(rand_cmd(ACT_EMIT), 1'b0, '0);
            end
        end

        // Drain, then give a stray strobe time to show up.
        start <= 1'b0;
        while (texel_due.size() != 0)
            @(posedge clk);
        repeat (QUIET_CYCLES) @(posedge clk);

        if (fail_cnt == 0 && texel_due.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

`default_nettype wire

FILE: files.f
design/grtg_pkg.sv
design/grtg_blend.sv
design/gradient_ramp_texel_generator_core.sv
tb/gradient_ramp_texel_generator_core_tb.sv
